// File: rtl/tlfs_pkg.sv
// Package for the three-level feedback scheduler: sizes, codes, entry and word types.
// No dependencies; imported by every module of the block.
`default_nettype none
package tlfs_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 8;
    localparam int NUM_Q       = 3;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_UPD  = 2'd1;
    localparam logic [1:0] MODE_PICK = 2'd2;

    localparam logic [1:0] LVL_BOTTOM = 2'd0;
    localparam logic [1:0] LVL_MID    = 2'd1;
    localparam logic [1:0] LVL_TOP    = 2'd2;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [15:0]        cycles;
        logic [15:0]        run;
        logic [15:0]        wait_p;
        logic               ready;
        logic signed [16:0] key;
    } entry_t;

    typedef struct packed {
        logic               ready;
        logic [15:0]        run;
        logic signed [16:0] key;
    } patch_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic patch;
    } cell_ctl_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  level;
        logic [7:0]  process_id;
        logic [15:0] total_cycles;
        logic [15:0] run_time;
        logic [15:0] wait_period;
        logic        is_ready;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  picked_id;
        logic [1:0]  picked_level;
        logic [16:0] slice;
        logic        unlimited;
        logic        all_empty;
        logic        overflow;
    } out_word_t;

endpackage
`default_nettype wire

// File: rtl/tlfs_cell.sv
// One queue slot: holds an entry, takes its neighbor's entry on a shift.
// Depends on tlfs_pkg.
`default_nettype none
module tlfs_cell import tlfs_pkg::*; (
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    nbr,
    input  wire entry_t    load_entry,
    input  wire patch_t    patch,
    output entry_t         q
);
    entry_t entry_reg, entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift) begin
            entry_next = nbr;
        end else if (ctl.load) begin
            entry_next = load_entry;
        end else if (ctl.patch) begin
            entry_next.ready = patch.ready;
            entry_next.run   = patch.run;
            entry_next.key   = patch.key;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;
endmodule
`default_nettype wire

// File: rtl/tlfs_mod_unit.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on tlfs_pkg.
`default_nettype none
module tlfs_mod_unit import tlfs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      rem
);
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          dvd_reg, dvd_next;
    logic [15:0]          dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [16:0]          trial;

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[15]};
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[15:0];
            end
            dvd_next = {dvd_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// File: rtl/three_level_feedback_scheduler_unit.sv
// Top level of the three-level feedback scheduler: three rings of slot cells,
// a scan sequencer and a remainder unit. Depends on tlfs_pkg, tlfs_cell, tlfs_mod_unit.
//
//  channel | ports                    | carries
//  --------+--------------------------+--------------------------------
//  in      | s_valid s_ready s_data   | one command word (add/update/pick)
//  out     | m_valid m_ready m_data   | one result word per command
//  config  | cfg_we cfg_wdata         | base_quantum, no wait
//
// Add runs the remainder unit that forms the bottom key, then loads the new entry.
// Update and pick rotate every ring once through its head slot; an update that hits
// then runs the remainder unit for its new key. One command is in work at a time.
// The result sits in an output register; a stalled m_ready holds only the finished
// command, a new one is taken as soon as the sequencer is back at idle.
// aresetn (synchronous) clears fill counts, base_quantum to 1, and the control.
// Slot contents have no reset; only slots below a fill count are ever used.
`default_nettype none
module three_level_feedback_scheduler_unit import tlfs_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [15:0]      base_reg, base_next;
    logic [CNT_W-1:0] cnt_reg [NUM_Q];
    logic [CNT_W-1:0] cnt_next [NUM_Q];
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [NUM_Q-1:0] have_reg, have_next;
    logic             m_valid_reg, m_valid_next;

    // payload
    in_word_t           in_reg, in_next;
    out_word_t          res_reg, res_next;
    out_word_t          out_reg, out_next;
    logic [IDX_W-1:0]   idx_reg [NUM_Q];
    logic [IDX_W-1:0]   idx_next [NUM_Q];
    logic [ID_BITS-1:0] pid_reg [NUM_Q];
    logic [ID_BITS-1:0] pid_next [NUM_Q];
    logic [15:0]        mcyc_reg [NUM_Q];
    logic [15:0]        mcyc_next [NUM_Q];
    logic [15:0]        mwait_reg [NUM_Q];
    logic [15:0]        mwait_next [NUM_Q];
    logic signed [16:0] best_reg, best_next;
    logic [1:0]         sel_q_reg, sel_q_next;
    logic [IDX_W-1:0]   sel_idx_reg, sel_idx_next;

    // ring control
    logic             rot, rm_en, ld_en, pt_en;
    logic [1:0]       rm_q;
    logic [IDX_W-1:0] rm_idx;
    logic [1:0]       chosen_q;
    logic             any_have;

    // remainder unit
    logic        div_start, div_done;
    logic [15:0] div_dvd, div_dvs, div_rem;

    // key build for a new or patched entry
    logic [15:0]        cyc_k, wait_k;
    logic signed [16:0] d_k, w_k, key_k;

    entry_t cells [NUM_Q][QUEUE_DEPTH];
    entry_t load_entry;
    patch_t patch;
    entry_t head;
    logic   v;

    assign cyc_k  = (in_reg.mode == MODE_ADD) ? in_reg.total_cycles : mcyc_reg[sel_q_reg];
    assign wait_k = (in_reg.mode == MODE_ADD) ? in_reg.wait_period  : mwait_reg[sel_q_reg];
    assign d_k    = $signed({1'b0, cyc_k}) - $signed({1'b0, in_reg.run_time});
    assign w_k    = $signed({1'b0, wait_k}) - $signed({1'b0, div_rem});
    assign key_k  = (wait_k == 16'd0) ? d_k : ((d_k <= w_k) ? d_k : w_k);

    always_comb begin
        load_entry.id     = in_reg.process_id[ID_BITS-1:0];
        load_entry.cycles = in_reg.total_cycles;
        load_entry.run    = in_reg.run_time;
        load_entry.wait_p = in_reg.wait_period;
        load_entry.ready  = in_reg.is_ready;
        load_entry.key    = key_k;
        patch.ready       = in_reg.is_ready;
        patch.run         = in_reg.run_time;
        patch.key         = key_k;
    end

    // highest level with a hit wins
    always_comb begin
        any_have = |have_reg;
        if (have_reg[LVL_TOP]) begin
            chosen_q = LVL_TOP;
        end else if (have_reg[LVL_MID]) begin
            chosen_q = LVL_MID;
        end else begin
            chosen_q = LVL_BOTTOM;
        end
    end

    always_comb begin
        state_next   = state_reg;
        base_next    = cfg_we ? cfg_wdata : base_reg;
        scan_next    = scan_reg;
        have_next    = have_reg;
        in_next      = in_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        best_next    = best_reg;
        sel_q_next   = sel_q_reg;
        sel_idx_next = sel_idx_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        for (int q = 0; q < NUM_Q; q++) begin
            cnt_next[q]   = cnt_reg[q];
            idx_next[q]   = idx_reg[q];
            pid_next[q]   = pid_reg[q];
            mcyc_next[q]  = mcyc_reg[q];
            mwait_next[q] = mwait_reg[q];
        end
        rot       = 1'b0;
        rm_en     = 1'b0;
        ld_en     = 1'b0;
        pt_en     = 1'b0;
        rm_q      = chosen_q;
        rm_idx    = idx_reg[chosen_q];
        div_start = 1'b0;
        div_dvd   = in_reg.run_time;
        div_dvs   = mwait_reg[chosen_q];
        head      = cells[0][0];
        v         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                div_dvd = s_data.run_time;
                div_dvs = s_data.wait_period;
                if (s_valid) begin
                    in_next   = s_data;
                    res_next  = '0;
                    have_next = '0;
                    scan_next = '0;
                    case (s_data.mode)
                        MODE_ADD: begin
                            if (s_data.level > LVL_TOP) begin
                                state_next = ST_DONE;
                            end else if (cnt_reg[s_data.level] >= CNT_W'(QUEUE_DEPTH)) begin
                                res_next.overflow = 1'b1;
                                state_next        = ST_DONE;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        MODE_UPD, MODE_PICK: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (in_reg.mode == MODE_ADD) begin
                        ld_en                   = 1'b1;
                        cnt_next[in_reg.level] = cnt_reg[in_reg.level] + 1'b1;
                    end else begin
                        pt_en = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                // every ring rotates; slot 0 holds original index scan_reg
                rot = 1'b1;
                for (int q = 0; q < NUM_Q; q++) begin
                    head = cells[q][0];
                    v    = CNT_W'(scan_reg) < cnt_reg[q];
                    if (in_reg.mode == MODE_UPD) begin
                        if (v && !have_reg[q] &&
                            head.id == in_reg.process_id[ID_BITS-1:0]) begin
                            have_next[q]  = 1'b1;
                            idx_next[q]   = scan_reg;
                            mcyc_next[q]  = head.cycles;
                            mwait_next[q] = head.wait_p;
                        end
                    end else if (q == 0) begin
                        // least key, strict compare keeps the oldest on a tie
                        if (v && head.ready && (!have_reg[q] || head.key < best_reg)) begin
                            have_next[q] = 1'b1;
                            idx_next[q]  = scan_reg;
                            pid_next[q]  = head.id;
                            best_next    = head.key;
                        end
                    end else begin
                        if (v && head.ready && !have_reg[q]) begin
                            have_next[q] = 1'b1;
                            idx_next[q]  = scan_reg;
                            pid_next[q]  = head.id;
                        end
                    end
                end
                if (scan_reg == IDX_W'(QUEUE_DEPTH - 1)) begin
                    scan_next  = '0;
                    state_next = ST_APPLY;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_APPLY: begin
                if (!any_have) begin
                    state_next = ST_DONE;
                end else if (in_reg.mode == MODE_PICK) begin
                    rm_en                  = 1'b1;
                    cnt_next[chosen_q]     = cnt_reg[chosen_q] - 1'b1;
                    res_next.found         = 1'b1;
                    res_next.picked_id     = 8'(pid_reg[chosen_q]);
                    res_next.picked_level  = chosen_q;
                    res_next.unlimited     = (chosen_q == LVL_BOTTOM);
                    if (chosen_q == LVL_TOP) begin
                        res_next.slice = {base_reg, 1'b0};
                    end else if (chosen_q == LVL_MID) begin
                        res_next.slice = {1'b0, base_reg};
                    end else begin
                        res_next.slice = '0;
                    end
                    state_next = ST_DONE;
                end else begin
                    sel_q_next   = chosen_q;
                    sel_idx_next = idx_reg[chosen_q];
                    div_start    = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next           = res_reg;
                    out_next.all_empty = (cnt_reg[0] == '0) && (cnt_reg[1] == '0) &&
                                         (cnt_reg[2] == '0);
                    m_valid_next       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_reg    <= 16'd1;
            scan_reg    <= '0;
            have_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int q = 0; q < NUM_Q; q++) begin
                cnt_reg[q] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            scan_reg    <= scan_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
            for (int q = 0; q < NUM_Q; q++) begin
                cnt_reg[q] <= cnt_next[q];
            end
        end
        in_reg      <= in_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        best_reg    <= best_next;
        sel_q_reg   <= sel_q_next;
        sel_idx_reg <= sel_idx_next;
        for (int q = 0; q < NUM_Q; q++) begin
            idx_reg[q]   <= idx_next[q];
            pid_reg[q]   <= pid_next[q];
            mcyc_reg[q]  <= mcyc_next[q];
            mwait_reg[q] <= mwait_next[q];
        end
    end

    tlfs_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .rem      (div_rem)
    );

    // Rings: slot i takes slot i+1, the last slot takes slot 0. A removal shifts
    // only the slots at and above the removed index.
    for (genvar gq = 0; gq < NUM_Q; gq++) begin : g_ring
        for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_slot
            cell_ctl_t ctl;
            always_comb begin
                ctl.shift = rot || (rm_en && rm_q == 2'(gq) && IDX_W'(gi) >= rm_idx);
                ctl.load  = ld_en && in_reg.level == 2'(gq) &&
                            cnt_reg[gq][IDX_W-1:0] == IDX_W'(gi);
                ctl.patch = pt_en && sel_q_reg == 2'(gq) && sel_idx_reg == IDX_W'(gi);
            end
            tlfs_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .nbr        (cells[gq][(gi + 1) % QUEUE_DEPTH]),
                .load_entry (load_entry),
                .patch      (patch),
                .q          (cells[gq][gi])
            );
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= CNT_W'(QUEUE_DEPTH) && cnt_reg[1] <= CNT_W'(QUEUE_DEPTH) &&
        cnt_reg[2] <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_unlim_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.unlimited |-> out_reg.picked_level == LVL_BOTTOM &&
        out_reg.found)
        else $error("unlimited word not from bottom queue");

    a_scan_home: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_APPLY |-> scan_reg == '0 && $past(state_reg) == ST_SCAN)
        else $error("rings not back home at apply");

endmodule
`default_nettype wire

// File: tb/tlfs_checker.sv
// Checker for the three-level feedback scheduler: watches both channels, keeps its own
// copy of the queues and base quantum, predicts each result word and compares it.
// Depends on tlfs_pkg.
`default_nettype none
module tlfs_checker import tlfs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_word_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_word_t   m_data,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  id;
        logic [15:0] cycles;
        logic [15:0] run;
        logic [15:0] wait_p;
        logic        ready;
    } proc_t;

    proc_t       queues[3][$];
    logic [15:0] quantum;
    out_word_t   results_due[$];

    function automatic int bottom_rank(proc_t p);
        int d;
        int w;
        d = int'(p.cycles) - int'(p.run);
        if (p.wait_p == 0) return d;
        w = int'(p.wait_p) - int'(p.run % p.wait_p);
        return (d <= w) ? d : w;
    endfunction

    function automatic out_word_t schedule(in_word_t c);
        out_word_t r;
        bit        hit;
        int        best;
        int        best_rank;
        int        k;
        r = '0;
        hit = 0;
        case (c.mode)
            MODE_ADD: begin
                if (c.level <= LVL_TOP) begin
                    if (queues[c.level].size() >= QUEUE_DEPTH) r.overflow = 1;
                    else queues[c.level].push_back('{c.process_id, c.total_cycles,
                                                     c.run_time, c.wait_period, c.is_ready});
                end
            end
            MODE_UPD: begin
                // top first, oldest first within a queue
                for (int q = 2; q >= 0 && !hit; q--)
                    for (int i = 0; i < queues[q].size() && !hit; i++)
                        if (queues[q][i].id == c.process_id) begin
                            queues[q][i].ready = c.is_ready;
                            queues[q][i].run   = c.run_time;
                            hit = 1;
                        end
            end
            MODE_PICK: begin
                for (int q = 2; q >= 1 && !hit; q--)
                    for (int i = 0; i < queues[q].size() && !hit; i++)
                        if (queues[q][i].ready) begin
                            hit = 1;
                            r.found = 1;
                            r.picked_id = queues[q][i].id;
                            r.picked_level = q[1:0];
                            r.slice = (q == 2) ? {quantum, 1'b0} : {1'b0, quantum};
                            queues[q].delete(i);
                        end
                if (!hit) begin
                    best = -1;
                    best_rank = 0;
                    for (int i = 0; i < queues[0].size(); i++)
                        if (queues[0][i].ready) begin
                            k = bottom_rank(queues[0][i]);
                            if (best < 0 || k < best_rank) begin
                                best = i;
                                best_rank = k;
                            end
                        end
                    if (best >= 0) begin
                        r.found = 1;
                        r.picked_id = queues[0][best].id;
                        r.picked_level = LVL_BOTTOM;
                        r.unlimited = 1;
                        queues[0].delete(best);
                    end
                end
            end
            default: ;
        endcase
        r.all_empty = (queues[0].size() == 0 && queues[1].size() == 0 &&
                       queues[2].size() == 0);
        return r;
    endfunction

    assign pending = results_due.size();

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            for (int q = 0; q < 3; q++) queues[q].delete();
            results_due.delete();
            quantum <= 16'd1;
            fail_count <= 0;
        end else begin
            if (cfg_we) quantum <= cfg_wdata;
            if (s_valid && s_ready) results_due.push_back(schedule(s_data));
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with nothing expected: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    if (want != m_data) begin
                        fail_count <= fail_count + 1;
                        if (want.found != m_data.found)
                            $error("found exp %0d got %0d", want.found, m_data.found);
                        if (want.picked_id != m_data.picked_id)
                            $error("picked_id exp %0d got %0d", want.picked_id,
                                   m_data.picked_id);
                        if (want.picked_level != m_data.picked_level)
                            $error("picked_level exp %0d got %0d", want.picked_level,
                                   m_data.picked_level);
                        if (want.slice != m_data.slice)
                            $error("slice exp %0d got %0d", want.slice, m_data.slice);
                        if (want.unlimited != m_data.unlimited)
                            $error("unlimited exp %0d got %0d", want.unlimited,
                                   m_data.unlimited);
                        if (want.all_empty != m_data.all_empty)
                            $error("all_empty exp %0d got %0d", want.all_empty,
                                   m_data.all_empty);
                        if (want.overflow != m_data.overflow)
                            $error("overflow exp %0d got %0d", want.overflow,
                                   m_data.overflow);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Top of the scheduler testbench: clock, reset, command stimulus, receiver stalls,
// config writes and the verdict. Depends on tlfs_pkg, the block and tlfs_checker.
`default_nettype none
module testbench;
    import tlfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;   // cycles with no word moving

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_word_t   m_data;
    logic        cfg_we = 0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    bit          hold_off = 0;    // long receiver stall request
    int          idle_cycles = 0;

    always #5 aclk = ~aclk;

    three_level_feedback_scheduler_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    tlfs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: random runs of ready and stall, or a long hold-off on request.
    initial begin
        int run_len;
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                @(posedge aclk);
            end else begin
                run_len = $urandom_range(1, 12);
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat (run_len) @(posedge aclk);
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

    // Offer one word and hold it until taken.
    task automatic send_word(in_word_t w);
        s_valid <= 1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Random gap between bursts; s_valid is dropped here and in drain().
    task automatic burst_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic in_word_t make_cmd(logic [1:0] mode, logic [1:0] lvl,
                                          logic [7:0] pid, logic [15:0] cyc,
                                          logic [15:0] run, logic [15:0] wt, logic rdy);
        in_word_t w;
        w.mode = mode; w.level = lvl; w.process_id = pid; w.total_cycles = cyc;
        w.run_time = run; w.wait_period = wt; w.is_ready = rdy;
        return w;
    endfunction

    // Random 16-bit value leaning toward edges so keys go negative and ties happen.
    function automatic logic [15:0] rand16();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_cmd();
        int sel;
        logic [1:0] mode;
        sel = $urandom_range(0, 99);
        if (sel < 45) mode = MODE_ADD;
        else if (sel < 65) mode = MODE_UPD;
        else if (sel < 97) mode = MODE_PICK;
        else mode = 2'd3;  // no-op
        return make_cmd(mode, ($urandom_range(0, 30) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                        rand16(), rand16(), rand16(), $urandom_range(0, 3) != 0);
    endfunction

    // Wait for every expected word, then let the block settle before a config write.
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_quantum(logic [15:0] q);
        cfg_we    <= 1;
        cfg_wdata <= q;
        @(posedge aclk);
        cfg_we    <= 0;
    endtask

    initial begin
        logic [15:0] quanta[4];
        quanta = '{16'd1, 16'hFFFF, 16'd0, 16'd300};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: pick on empty, extremes, ties, negative keys, wait zero, updates.
        send_word(make_cmd(MODE_PICK, LVL_TOP, 8'd0, 0, 0, 0, 0));
        send_word(make_cmd(MODE_ADD, LVL_BOTTOM, 8'd1, 16'd0, 16'hFFFF, 16'd0, 1));
        send_word(make_cmd(MODE_ADD, LVL_BOTTOM, 8'd2, 16'hFFFF, 16'd0, 16'hFFFF, 1));
        send_word(make_cmd(MODE_ADD, LVL_BOTTOM, 8'd3, 16'd10, 16'd5, 16'd0, 1));
        send_word(make_cmd(MODE_ADD, LVL_BOTTOM, 8'd4, 16'd10, 16'd5, 16'd0, 1));
        send_word(make_cmd(MODE_ADD, LVL_BOTTOM, 8'd5, 16'd100, 16'd7, 16'd4, 0));
        send_word(make_cmd(MODE_ADD, LVL_MID, 8'hFF, 16'd1, 16'd1, 16'd1, 0));
        send_word(make_cmd(MODE_ADD, LVL_TOP, 8'd0, 16'd1, 16'd1, 16'd1, 0));
        send_word(make_cmd(MODE_ADD, 2'd3, 8'd9, 16'd1, 16'd1, 16'd1, 1));
        send_word(make_cmd(MODE_PICK, LVL_TOP, 8'd0, 0, 0, 0, 0));
        send_word(make_cmd(MODE_UPD, LVL_TOP, 8'd0, 0, 16'd3, 0, 1));
        send_word(make_cmd(MODE_UPD, LVL_TOP, 8'hFF, 0, 16'hFFFF, 0, 1));
        send_word(make_cmd(MODE_UPD, LVL_TOP, 8'd77, 0, 16'd3, 0, 1));
        send_word(make_cmd(MODE_UPD, LVL_TOP, 8'd5, 16'hFFFF, 16'd9, 16'hFFFF, 1));
        send_word(make_cmd(2'd3, 2'd3, 8'hAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        repeat (7) send_word(make_cmd(MODE_PICK, LVL_TOP, 8'd0, 0, 0, 0, 0));
        drain();

        // Fill the top queue past full with duplicate ids, then update the first match.
        for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
            send_word(make_cmd(MODE_ADD, LVL_TOP, 8'd7, 16'($urandom), 16'($urandom),
                               16'($urandom), i[0]));
            burst_gap();
        end
        send_word(make_cmd(MODE_UPD, LVL_TOP, 8'd7, 0, 16'd1, 0, 1));
        // Receiver holds off while the sender keeps offering picks.
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 20; i++) send_word(make_cmd(MODE_PICK, LVL_TOP, 0, 0, 0, 0, 0));
        join
        drain();

        // Random phases at several quanta; ready flags refreshed at the end of each phase.
        foreach (quanta[p]) begin
            write_quantum(quanta[p]);
            for (int i = 0; i < 100; i++) begin
                send_word(random_cmd());
                if ($urandom_range(0, 5) == 0) burst_gap();
            end
            for (int i = 0; i < 35; i++) send_word(make_cmd(MODE_UPD, 0, 8'($urandom_range(0, 15)),
                                                            0, rand16(), 0, 1));
            drain();
        end

        if (fail_count == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
